// ===== sv/hrhp_pkg.sv =====
// Shared types, codes and match tables for the HTTP request header parser.
package hrhp_pkg;

   localparam int LENGTH_BITS_DEFAULT = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = 2;

   typedef enum logic [3:0] {
      PH_METHOD,
      PH_PATH,
      PH_VERSION,
      PH_NAME,
      PH_BLANK,
      PH_VALUE,
      PH_NUMBER,
      PH_SKIP,
      PH_BODY,
      PH_ACCEPT,
      PH_REJECT
   } phase_type;

   typedef enum logic [1:0] {
      NUM_SPACE,
      NUM_SIGN,
      NUM_DIGIT,
      NUM_DONE
   } num_phase_type;

   localparam logic [2:0] TAG_NONE    = 3'd0;
   localparam logic [2:0] TAG_PATH    = 3'd1;
   localparam logic [2:0] TAG_VERSION = 3'd2;
   localparam logic [2:0] TAG_HOST    = 3'd3;
   localparam logic [2:0] TAG_BODY    = 3'd7;

   localparam logic [1:0] STATUS_BUSY   = 2'd0;
   localparam logic [1:0] STATUS_ACCEPT = 2'd1;
   localparam logic [1:0] STATUS_REJECT = 2'd2;

   localparam logic [2:0] METHOD_CODE_POST = 3'd2;
   localparam logic [2:0] METHOD_CODE_PUT  = 3'd3;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam int NUM_METHODS = 4;
   localparam int NUM_NAMES = 5;
   localparam int NAME_LENGTH_IDX = 4;

   // Rows are right-aligned: the last character sits in the low byte.
   localparam logic [127:0] METHOD_ROW [NUM_METHODS] = '{
      128'("GET "), 128'("POST "), 128'("PUT "), 128'("DELETE ")};
   localparam logic [4:0] METHOD_LEN [NUM_METHODS] = '{5'd4, 5'd5, 5'd4, 5'd7};

   localparam logic [127:0] NAME_ROW [NUM_NAMES] = '{
      128'("Host: "), 128'("Accept: "), 128'("User-Agent: "),
      128'("Content-Type: "), 128'("Content-Length: ")};
   localparam logic [4:0] NAME_LEN [NUM_NAMES] = '{5'd6, 5'd8, 5'd12, 5'd14, 5'd16};

   typedef struct packed {
      logic [31:0] length_value;
      logic [1:0]  parse_status;
      logic [2:0]  method_code;
      logic [7:0]  out_byte;
      logic [2:0]  field_tag;
      logic        last_in_run;
   } rsp_entry_type;

   typedef struct packed {
      logic          push;
      logic          two;
      rsp_entry_type first;
      rsp_entry_type second;
   } push_bundle_type;

   // Character at position pos of a right-aligned row of length len.
   function automatic logic [7:0] row_byte(input logic [127:0] row, input logic [4:0] len,
                                          input logic [3:0] pos);
      logic [4:0]   k;
      logic [127:0] shifted;
      begin
         k = len - 5'd1 - {1'b0, pos};
         shifted = row >> {k, 3'b000};
         return shifted[7:0];
      end
   endfunction

endpackage

// ===== sv/http_request_header_parser.sv =====
// Top level of the byte-serial HTTP request header parser.
//
//  channel | direction | tdata (low bit up)                         | tuser            | tlast
//  req_    | in        | data_byte[7:0]                             | start_of_request | end_of_buffer
//  rsp_    | out       | field_tag, out_byte, method_code,          | -                | last_in_run
//          |           | parse_status, length_value (48 bits)       |                  |
//
// Each request byte is parsed in the cycle it is transferred: the next parse
// state and its one or two results are computed from the state registers and
// the incoming byte, and the results go into a four-entry result queue.
// One byte per cycle is sustained while the queue has room; a byte that
// releases a held CR yields two results. req_tready holds low while the queue
// has fewer than two free entries. Synchronous reset clears parse state and
// the queue; start_of_request clears parse state in-band.
module http_request_header_parser #(
   parameter int LENGTH_BITS = hrhp_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte[7:0]
   input  logic        req_tuser,   // start_of_request
   input  logic        req_tlast,   // end_of_buffer
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // field_tag[2:0], out_byte[10:3], method_code[13:11],
                                    // parse_status[15:14], length_value[47:16]
   output logic        rsp_tlast    // last_in_run
);

   localparam int LB = LENGTH_BITS;
   localparam logic [LB-1:0] LEN_SIGN = {1'b1, {(LB-1){1'b0}}};

   hrhp_pkg::phase_type     phase_ff, phase_in;
   hrhp_pkg::num_phase_type num_phase_ff, num_phase_in;
   logic [3:0]    match_pos_ff, match_pos_in;
   logic [4:0]    cand_ff, cand_in;
   logic          held_cr_ff, held_cr_in;
   logic [2:0]    method_ff, method_in;
   logic [LB-1:0] len_acc_ff, len_acc_in;
   logic [LB-1:0] mag_ff, mag_in;
   logic          num_neg_ff, num_neg_in;
   logic [LB-1:0] body_ff, body_in;
   logic [2:0]    active_ff, active_in;

   logic [2:0] tag0, tag1;
   logic [7:0] byte0, byte1;
   logic [1:0] res_count;

   logic req_fire;
   logic room;
   hrhp_pkg::push_bundle_type push;
   hrhp_pkg::rsp_entry_type   rsp_entry;
   logic signed [LB-1:0] len_signed;
   logic [1:0] status;

   assign req_fire = req_tvalid && req_tready;
   assign req_tready = room;

   // Parse one byte: next state and results.
   always_comb begin
      logic [7:0]    b;
      logic [3:0]    live_m;
      logic [4:0]    live_n;
      logic          done_m, done_n, line_end, cr_data, is_digit, is_space;
      logic [1:0]    hit_m;
      logic [2:0]    hit_n;
      logic [2:0]    line_tag;
      logic [LB-1:0] m, lim;
      logic [LB+3:0] t;
      logic [7:0]    d;

      b = req_tdata;
      phase_in = phase_ff;
      num_phase_in = num_phase_ff;
      match_pos_in = match_pos_ff;
      cand_in = cand_ff;
      held_cr_in = held_cr_ff;
      method_in = method_ff;
      len_acc_in = len_acc_ff;
      mag_in = mag_ff;
      num_neg_in = num_neg_ff;
      body_in = body_ff;
      active_in = active_ff;
      tag0 = hrhp_pkg::TAG_NONE;
      tag1 = hrhp_pkg::TAG_NONE;
      byte0 = '0;
      byte1 = '0;
      res_count = 2'd0;
      live_m = '0;
      live_n = '0;
      done_m = 1'b0;
      done_n = 1'b0;
      hit_m = '0;
      hit_n = '0;
      line_end = 1'b0;
      cr_data = 1'b0;
      line_tag = hrhp_pkg::TAG_NONE;
      m = '0;
      lim = '0;
      t = '0;
      d = b - hrhp_pkg::CHAR_ZERO;
      is_digit = (b >= hrhp_pkg::CHAR_ZERO) && (b <= hrhp_pkg::CHAR_NINE);
      is_space = (b == hrhp_pkg::CHAR_SPACE) || ((b >= hrhp_pkg::CHAR_TAB) && (b <= hrhp_pkg::CHAR_CR));

      if (req_tuser) begin
         phase_in = hrhp_pkg::PH_METHOD;
         match_pos_in = '0;
         cand_in = 5'h1F;
         held_cr_in = 1'b0;
         method_in = '0;
         len_acc_in = '1;
         num_phase_in = hrhp_pkg::NUM_SPACE;
         num_neg_in = 1'b0;
         body_in = '0;
         active_in = '0;
      end

      // Candidate matching for both tables.
      for (int i = 0; i < hrhp_pkg::NUM_METHODS; i++) begin
         live_m[i] = cand_in[i] && ({1'b0, match_pos_in} < hrhp_pkg::METHOD_LEN[i]) &&
            (hrhp_pkg::row_byte(hrhp_pkg::METHOD_ROW[i], hrhp_pkg::METHOD_LEN[i],
                                match_pos_in) == b);
      end
      for (int i = hrhp_pkg::NUM_METHODS - 1; i >= 0; i--) begin
         if (live_m[i] && (hrhp_pkg::METHOD_LEN[i] == {1'b0, match_pos_in} + 5'd1)) begin
            done_m = 1'b1;
            hit_m = 2'(i);
         end
      end
      for (int i = 0; i < hrhp_pkg::NUM_NAMES; i++) begin
         live_n[i] = cand_in[i] && ({1'b0, match_pos_in} < hrhp_pkg::NAME_LEN[i]) &&
            (hrhp_pkg::row_byte(hrhp_pkg::NAME_ROW[i], hrhp_pkg::NAME_LEN[i],
                                match_pos_in) == b);
      end
      for (int i = hrhp_pkg::NUM_NAMES - 1; i >= 0; i--) begin
         if (live_n[i] && (hrhp_pkg::NAME_LEN[i] == {1'b0, match_pos_in} + 5'd1)) begin
            done_n = 1'b1;
            hit_n = 3'(i);
         end
      end

      if (phase_in != hrhp_pkg::PH_ACCEPT && phase_in != hrhp_pkg::PH_REJECT) begin
         if (b == hrhp_pkg::CHAR_NUL && phase_in != hrhp_pkg::PH_BODY) begin
            phase_in = hrhp_pkg::PH_REJECT;
         end else begin
            case (phase_in)
               hrhp_pkg::PH_METHOD: begin
                  if (live_m == '0) begin
                     phase_in = hrhp_pkg::PH_REJECT;
                  end else if (done_m) begin
                     method_in = {1'b0, hit_m} + 3'd1;
                     match_pos_in = '0;
                     phase_in = hrhp_pkg::PH_PATH;
                  end else begin
                     cand_in = {1'b0, live_m};
                     match_pos_in = match_pos_in + 4'd1;
                  end
               end
               hrhp_pkg::PH_PATH: begin
                  if (b == hrhp_pkg::CHAR_SPACE) begin
                     phase_in = hrhp_pkg::PH_VERSION;
                  end else begin
                     tag0 = hrhp_pkg::TAG_PATH;
                     byte0 = b;
                     res_count = 2'd1;
                  end
               end
               hrhp_pkg::PH_NAME: begin
                  if (match_pos_in == '0 && b == hrhp_pkg::CHAR_CR) begin
                     phase_in = hrhp_pkg::PH_BLANK;
                  end else if (live_n == '0) begin
                     phase_in = hrhp_pkg::PH_SKIP;
                     held_cr_in = (b == hrhp_pkg::CHAR_CR);
                  end else if (done_n && hit_n == 3'(hrhp_pkg::NAME_LENGTH_IDX)) begin
                     phase_in = hrhp_pkg::PH_NUMBER;
                     num_phase_in = hrhp_pkg::NUM_SPACE;
                     num_neg_in = 1'b0;
                  end else if (done_n) begin
                     phase_in = hrhp_pkg::PH_VALUE;
                     active_in = hrhp_pkg::TAG_HOST + hit_n;
                  end else begin
                     cand_in = live_n;
                     match_pos_in = match_pos_in + 4'd1;
                  end
               end
               hrhp_pkg::PH_BLANK: begin
                  if (b == hrhp_pkg::CHAR_LF) begin
                     if (method_in != hrhp_pkg::METHOD_CODE_POST &&
                         method_in != hrhp_pkg::METHOD_CODE_PUT) begin
                        phase_in = hrhp_pkg::PH_ACCEPT;
                     end else if (len_acc_in == '1) begin
                        phase_in = hrhp_pkg::PH_REJECT;
                     end else if (len_acc_in == '0 || len_acc_in[LB-1]) begin
                        phase_in = hrhp_pkg::PH_ACCEPT;
                     end else begin
                        body_in = len_acc_in;
                        phase_in = hrhp_pkg::PH_BODY;
                     end
                  end else begin
                     phase_in = hrhp_pkg::PH_SKIP;
                     held_cr_in = (b == hrhp_pkg::CHAR_CR);
                  end
               end
               hrhp_pkg::PH_VERSION, hrhp_pkg::PH_VALUE,
               hrhp_pkg::PH_NUMBER, hrhp_pkg::PH_SKIP: begin
                  line_tag = (phase_in == hrhp_pkg::PH_VERSION) ? hrhp_pkg::TAG_VERSION
                                                                : active_in;
                  if (held_cr_in) begin
                     held_cr_in = 1'b0;
                     if (b == hrhp_pkg::CHAR_LF) begin
                        line_end = 1'b1;
                     end else begin
                        cr_data = 1'b1;
                     end
                  end
                  if (line_end) begin
                     phase_in = hrhp_pkg::PH_NAME;
                     match_pos_in = '0;
                     cand_in = 5'h1F;
                  end else begin
                     held_cr_in = (b == hrhp_pkg::CHAR_CR);
                     if (phase_in == hrhp_pkg::PH_VERSION || phase_in == hrhp_pkg::PH_VALUE) begin
                        if (cr_data) begin
                           tag0 = line_tag;
                           byte0 = hrhp_pkg::CHAR_CR;
                           res_count = 2'd1;
                        end
                        if (b != hrhp_pkg::CHAR_CR) begin
                           if (cr_data) begin
                              tag1 = line_tag;
                              byte1 = b;
                              res_count = 2'd2;
                           end else begin
                              tag0 = line_tag;
                              byte0 = b;
                              res_count = 2'd1;
                           end
                        end
                     end else if (phase_in == hrhp_pkg::PH_NUMBER) begin
                        // A released CR is whitespace first, a terminator later.
                        if (cr_data && num_phase_in != hrhp_pkg::NUM_SPACE) begin
                           num_phase_in = hrhp_pkg::NUM_DONE;
                        end
                        if (b != hrhp_pkg::CHAR_CR) begin
                           if (num_phase_in == hrhp_pkg::NUM_SPACE && is_space) begin
                              num_phase_in = num_phase_in;
                           end else if (num_phase_in == hrhp_pkg::NUM_SPACE &&
                                        (b == hrhp_pkg::CHAR_PLUS || b == hrhp_pkg::CHAR_MINUS)) begin
                              num_neg_in = (b == hrhp_pkg::CHAR_MINUS);
                              num_phase_in = hrhp_pkg::NUM_SIGN;
                           end else if (!is_digit || num_phase_in == hrhp_pkg::NUM_DONE) begin
                              num_phase_in = hrhp_pkg::NUM_DONE;
                           end else begin
                              m = (num_phase_in == hrhp_pkg::NUM_DIGIT) ? mag_in : '0;
                              lim = num_neg_in ? LEN_SIGN : LEN_SIGN - 1'b1;
                              t = ({4'b0, m} << 3) + ({4'b0, m} << 1) + (LB+4)'(d[3:0]);
                              m = (t > {4'b0, lim}) ? lim : t[LB-1:0];
                              mag_in = m;
                              len_acc_in = num_neg_in ? (~m + 1'b1) : m;
                              num_phase_in = hrhp_pkg::NUM_DIGIT;
                           end
                        end
                     end
                  end
               end
               hrhp_pkg::PH_BODY: begin
                  tag0 = hrhp_pkg::TAG_BODY;
                  byte0 = b;
                  res_count = 2'd1;
                  body_in = body_in - 1'b1;
                  if (body_in == '0) begin
                     phase_in = hrhp_pkg::PH_ACCEPT;
                  end
               end
               default: begin
                  phase_in = hrhp_pkg::PH_REJECT;
               end
            endcase
         end
         if (req_tlast && phase_in != hrhp_pkg::PH_ACCEPT) begin
            phase_in = hrhp_pkg::PH_REJECT;
         end
      end
   end

   assign status = (phase_in == hrhp_pkg::PH_ACCEPT) ? hrhp_pkg::STATUS_ACCEPT :
                   (phase_in == hrhp_pkg::PH_REJECT) ? hrhp_pkg::STATUS_REJECT :
                                                       hrhp_pkg::STATUS_BUSY;
   assign len_signed = len_acc_in;

   // Build the queue push: an item with no data still gives one empty result.
   always_comb begin
      push.push = req_fire;
      push.two = (res_count == 2'd2);
      push.first.length_value = 32'(len_signed);
      push.first.parse_status = status;
      push.first.method_code = method_in;
      push.first.out_byte = byte0;
      push.first.field_tag = tag0;
      push.first.last_in_run = (res_count != 2'd2);
      push.second = push.first;
      push.second.out_byte = byte1;
      push.second.field_tag = tag1;
      push.second.last_in_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= hrhp_pkg::PH_METHOD;
         num_phase_ff <= hrhp_pkg::NUM_SPACE;
         match_pos_ff <= '0;
         cand_ff <= 5'h1F;
         held_cr_ff <= 1'b0;
         method_ff <= '0;
         len_acc_ff <= '1;
         mag_ff <= '0;
         num_neg_ff <= 1'b0;
         body_ff <= '0;
         active_ff <= '0;
      end else if (req_fire) begin
         phase_ff <= phase_in;
         num_phase_ff <= num_phase_in;
         match_pos_ff <= match_pos_in;
         cand_ff <= cand_in;
         held_cr_ff <= held_cr_in;
         method_ff <= method_in;
         len_acc_ff <= len_acc_in;
         mag_ff <= mag_in;
         num_neg_ff <= num_neg_in;
         body_ff <= body_in;
         active_ff <= active_in;
      end
   end

   hrhp_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_in   (push),
      .room      (room),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_entry (rsp_entry)
   );

   assign rsp_tdata = {rsp_entry.length_value, rsp_entry.parse_status, rsp_entry.method_code,
                       rsp_entry.out_byte, rsp_entry.field_tag};
   assign rsp_tlast = rsp_entry.last_in_run;

endmodule

// ===== sv/hrhp_result_queue.sv =====
// Four-entry result queue that takes one or two results per transfer.
module hrhp_result_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  hrhp_pkg::push_bundle_type      push_in,
   output logic                           room,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output hrhp_pkg::rsp_entry_type        rsp_entry
);

   hrhp_pkg::rsp_entry_type entry_ff [hrhp_pkg::QUEUE_DEPTH];
   logic [hrhp_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [hrhp_pkg::QUEUE_PTR_BITS:0]   count_ff, count_in;
   logic [hrhp_pkg::QUEUE_PTR_BITS-1:0] wr_next;
   logic pop;

   assign pop = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_entry = entry_ff[rd_ptr_ff];
   assign room = (count_ff <= (hrhp_pkg::QUEUE_PTR_BITS+1)'(hrhp_pkg::QUEUE_DEPTH - 2));
   assign wr_next = wr_ptr_ff + 1'b1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      count_in = count_ff;
      if (push_in.push) begin
         wr_ptr_in = push_in.two ? wr_ptr_ff + 2'd2 : wr_next;
         count_in = count_in + (push_in.two ? 3'd2 : 3'd1);
      end
      if (pop) begin
         count_in = count_in - 3'd1;
      end
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_in.push) begin
         entry_ff[wr_ptr_ff] <= push_in.first;
         if (push_in.two) begin
            entry_ff[wr_next] <= push_in.second;
         end
      end
   end

endmodule
